>>> src/ipd_payload_deframer_unit_assert.svh
// Assertion macros for the IPD deframer unit.
`ifndef IPD_PAYLOAD_DEFRAMER_UNIT_ASSERT_SVH
`define IPD_PAYLOAD_DEFRAMER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IPD_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define IPD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> src/ipd_pkg.sv
// Shared types, constants and helpers for the IPD deframer unit.
package ipd_pkg;

    localparam int IPD_FIFO_DEPTH = 256;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_LINK  = 2'd3
    } kind_t;

    // Commands handed from the parser to the execution side
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_PUSH  = 3'd1,
        OP_POP   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_LINK  = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       in_frame;
        logic       frame_end;
        logic [7:0] data;        // payload byte or new link id
        logic       flag;        // new link valid flag
        logic [7:0] frame_link;
    } cmd_t;

    typedef struct packed {
        logic        in_frame;
        logic [7:0]  pop_byte;
        logic        pop_valid;
        logic [7:0]  fifo_level;
        logic [15:0] drop_total;
        logic        link_open;
        logic [7:0]  link_number;
        logic        link_adopted;
        logic        frame_done;
    } res_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [2:0] PREFIX_LAST = 3'd4;

    // Expected character of "+IPD," at a given match position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        c = CH_PLUS;
        case (pos)
            3'd0:    c = CH_PLUS;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = CH_COMMA;
            default: c = CH_PLUS;
        endcase
        return c;
    endfunction

endpackage

>>> src/ipd_payload_deframer_unit.sv
// Top level of the IPD deframer unit: parser, command queue and executor.
//
// Channel  Dir  tdata (low bit up)                                  tuser / tlast
// s_axis   in   rx_byte[7:0] link_open_in[8] link_number_in[16:9]   tuser: kind
// m_axis   out  in_frame[0] pop_byte[8:1] pop_valid[9]              tlast: frame_done
//               fifo_level[17:10] drop_total[33:18] link_open[34]
//               link_number[42:35] link_adopted[43]
//
// One item per cycle sustained while the output takes results. The parser works in the
// accept cycle, the command queue registers the command, the executor then updates the
// FIFO, and the payload RAM's registered read fills in the popped byte with the result.
// A two-entry command queue lets the parser keep accepting while the output stalls, until both entries are full.
// Reset is asynchronous; the payload RAM needs no clearing after reset.
module ipd_payload_deframer_unit
    import ipd_pkg::*;
#(
    parameter int FIFO_DEPTH = IPD_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_byte, link_open_in, link_number_in, pad
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // in_frame, pop_byte, pop_valid, fifo_level,
                                        // drop_total, link_open, link_number,
                                        // link_adopted, pad
    output logic        m_axis_tlast    // frame_done
);

    cmd_t front_cmd, q_cmd;
    logic q_valid, q_ready;
    logic accept;
    res_t res;

    assign accept = s_axis_tvalid && s_axis_tready;

    ipd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .kind           (s_axis_tuser),
        .rx_byte        (s_axis_tdata[7:0]),
        .link_open_in   (s_axis_tdata[8]),
        .link_number_in (s_axis_tdata[16:9]),
        .cmd            (front_cmd)
    );

    ipd_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    ipd_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Output packing
    assign m_axis_tdata = {4'd0, res.link_adopted, res.link_number, res.link_open,
                           res.drop_total, res.fifo_level, res.pop_valid, res.pop_byte,
                           res.in_frame};
    assign m_axis_tlast = res.frame_done;

`include "ipd_payload_deframer_unit_assert.svh"

    `IPD_ASSERT_IMPL(a_adopt_at_end, m_axis_tvalid && res.link_adopted, res.frame_done, "link adopted outside frame end")
    `IPD_ASSERT_IMPL(a_end_in_frame, m_axis_tvalid && res.frame_done, res.in_frame, "frame end on byte outside frame")
    `IPD_ASSERT_NEVER(a_pop_vs_byte, m_axis_tvalid && res.pop_valid && res.in_frame, "pop result marked as frame byte")
    `IPD_ASSERT_IMPL(a_full_has_head, !s_axis_tready, q_valid, "queue full without head entry")

endmodule

>>> src/ipd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/ipd_front.sv
// Front end: prefix hunt and header parse, turns each item into a command.
module ipd_front
    import ipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    input  logic       link_open_in,
    input  logic [7:0] link_number_in,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic        second_reg, second_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0]  link_reg, link_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;

    logic        is_digit;
    logic [15:0] accum_x10;
    logic [15:0] count_inc;

    assign is_digit  = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign accum_x10 = {accum_reg[12:0], 3'b000} + {accum_reg[14:0], 1'b0};
    assign count_inc = count_reg + 16'd1;

    // Parse step and command build
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        second_next = second_reg;
        accum_next  = accum_reg;
        link_next   = link_reg;
        length_next = length_reg;
        count_next  = count_reg;

        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.data       = rx_byte;
        cmd.flag       = link_open_in;
        cmd.frame_link = link_reg;

        unique case (kind_t'(kind))
            KIND_BYTE:
            begin
                unique case (phase_reg)
                    PH_HDR:
                    begin
                        cmd.in_frame = 1'b1;
                        priority if (is_digit)
                        begin
                            accum_next = accum_x10 + {8'd0, rx_byte - CH_0};
                        end
                        else if (rx_byte == CH_COMMA && !second_reg)
                        begin
                            link_next   = accum_reg[7:0];
                            accum_next  = '0;
                            second_next = 1'b1;
                        end
                        else if (rx_byte == CH_COLON)
                        begin
                            if (!second_reg)
                            begin
                                link_next = '0;
                            end
                            length_next = accum_reg;
                            count_next  = '0;
                            phase_next  = (accum_reg != '0) ? PH_PAY : PH_HUNT;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end
                    end
                    PH_PAY:
                    begin
                        cmd.in_frame = 1'b1;
                        cmd.op       = OP_PUSH;
                        count_next   = count_inc;
                        if (count_inc >= length_reg)
                        begin
                            cmd.frame_end = 1'b1;
                            phase_next    = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        // hunting; the unused phase code behaves the same
                        phase_next = PH_HUNT;
                        if (rx_byte == prefix_char(pos_reg))
                        begin
                            if (pos_reg == PREFIX_LAST)
                            begin
                                pos_next     = '0;
                                phase_next   = PH_HDR;
                                second_next  = 1'b0;
                                accum_next   = '0;
                                cmd.in_frame = 1'b1;
                            end
                            else
                            begin
                                pos_next = pos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            pos_next = (rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
                        end
                    end
                endcase
            end
            KIND_POP:
            begin
                cmd.op = OP_POP;
            end
            KIND_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            KIND_LINK:
            begin
                cmd.op   = OP_LINK;
                cmd.data = link_number_in;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= '0;
            second_reg <= 1'b0;
            accum_reg  <= '0;
            link_reg   <= '0;
            length_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            second_reg <= second_next;
            accum_reg  <= accum_next;
            link_reg   <= link_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/ipd_cmd_queue.sv
// Two-entry command queue between parser and execution side.
module ipd_cmd_queue
    import ipd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    logic       tail;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[head_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign tail      = head_reg ^ count_reg[0];

    // Occupancy and head pointer
    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= in_cmd;
        end
    end

endmodule

>>> src/ipd_back.sv
// Back end: payload FIFO, drop counter, link state and result register.
module ipd_back
    import ipd_pkg::*;
#(
    parameter int FIFO_DEPTH = IPD_FIFO_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [LVL_W-1:0] DEPTH_L  = LVL_W'(FIFO_DEPTH);
    localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(255);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [15:0]      drop_reg, drop_next;
    logic             flag_reg, flag_next;
    logic [7:0]       id_reg, id_next;
    res_t             res_reg, res_next;
    logic             res_valid_reg;

    logic             fire;
    logic             ram_wr, ram_rd;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    logic [LVL_W-1:0] level_raw;
    logic [7:0]       ram_q;

    assign fire       = cmd_valid && (!res_valid_reg || res_ready);
    assign cmd_ready  = !res_valid_reg || res_ready;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    // Execute one command
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        drop_next   = drop_reg;
        flag_next   = flag_reg;
        id_next     = id_reg;
        ram_wr      = 1'b0;
        ram_rd      = 1'b0;
        res_next    = '0;

        unique case (cmd.op)
            OP_PUSH:
            begin
                if (wr_ptr_inc == rd_ptr_reg)
                begin
                    drop_next = drop_reg + 16'd1;
                end
                else
                begin
                    ram_wr      = fire;
                    wr_ptr_next = wr_ptr_inc;
                end
            end
            OP_POP:
            begin
                if (rd_ptr_reg != wr_ptr_reg)
                begin
                    ram_rd             = fire;
                    res_next.pop_valid = 1'b1;
                    rd_ptr_next        = rd_ptr_inc;
                end
            end
            OP_CLEAR:
            begin
                rd_ptr_next = wr_ptr_reg;
            end
            OP_LINK:
            begin
                flag_next = cmd.flag;
                id_next   = cmd.data;
            end
            default:
            begin
            end
        endcase

        // frame end takes over the frame's link when it is new
        if (cmd.frame_end)
        begin
            res_next.frame_done = 1'b1;
            if (!flag_reg || id_reg != cmd.frame_link)
            begin
                id_next               = cmd.frame_link;
                flag_next             = 1'b1;
                res_next.link_adopted = 1'b1;
            end
        end

        // level after this command, saturated to eight bits
        if (wr_ptr_next >= rd_ptr_next)
        begin
            level_raw = LVL_W'(wr_ptr_next) - LVL_W'(rd_ptr_next);
        end
        else
        begin
            level_raw = LVL_W'(wr_ptr_next) + DEPTH_L - LVL_W'(rd_ptr_next);
        end

        res_next.in_frame    = cmd.in_frame;
        res_next.fifo_level  = (level_raw > LVL_MAX) ? 8'hFF : level_raw[7:0];
        res_next.drop_total  = drop_next;
        res_next.link_open   = flag_next;
        res_next.link_number = id_next;
    end

    ipd_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data (cmd.data),
        .rd_en   (ram_rd),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_q)
    );

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            drop_reg      <= '0;
            flag_reg      <= 1'b0;
            id_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                drop_reg   <= drop_next;
                flag_reg   <= flag_next;
                id_reg     <= id_next;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // RAM read data holds until the next pop issues
    always_comb
    begin
        res          = res_reg;
        res.pop_byte = res_reg.pop_valid ? ram_q : 8'd0;
    end

    assign res_valid = res_valid_reg;

endmodule
